>>> sv/ujes_pkg.sv
// Shared types, constants and the code point encoder for the UTF-16 to UTF-8 JSON escaper.
// Used by ujes_front, ujes_queue, ujes_back and the top level. No dependencies.
package ujes_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int MAX_BYTES   = 6;

   localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
   localparam logic [5:0]  HIGH_SURR_TAG  = 6'b110110;
   localparam logic [5:0]  LOW_SURR_TAG   = 6'b110111;
   localparam logic [10:0] PLANE_OFFSET   = 11'd64;

   // UTF-8 text of U+FFFD, first byte at index 0.
   localparam logic [2:0][7:0] FFFD_UTF8 = {8'hBD, 8'hBF, 8'hEF};

   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   // One encoded code point: len bytes, first byte at index 0.
   typedef struct packed {
      logic [2:0]                 len;
      logic [MAX_BYTES-1:0][7:0]  bytes;
   } enc_type;

   // One queue entry: an optional U+FFFD ahead of an optional encoded code point.
   typedef struct packed {
      logic                       prefix;
      logic [2:0]                 len;
      logic [MAX_BYTES-1:0][7:0]  bytes;
      logic                       at_end;
   } rec_type;

   typedef struct packed {
      logic full;
      logic head_valid;
   } q_status_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] r;
      if (v < 4'd10) begin
         r = 8'h30 + {4'd0, v};
      end else begin
         r = 8'h37 + {4'd0, v};
      end
      return r;
   endfunction

   function automatic enc_type encode_cp(input logic [20:0] cp);
      enc_type e;
      e.len   = 3'd0;
      e.bytes = '0;
      if (cp < 21'h80) begin
         unique case (cp[7:0]) inside
            CH_QUOTE, CH_BSLASH: begin
               e.len = 3'd2; e.bytes[0] = CH_BSLASH; e.bytes[1] = cp[7:0];
            end
            CH_LF: begin
               e.len = 3'd2; e.bytes[0] = CH_BSLASH; e.bytes[1] = CH_N;
            end
            CH_CR: begin
               e.len = 3'd2; e.bytes[0] = CH_BSLASH; e.bytes[1] = CH_R;
            end
            CH_TAB: begin
               e.len = 3'd2; e.bytes[0] = CH_BSLASH; e.bytes[1] = CH_T;
            end
            default: begin
               if (cp < 21'h20) begin
                  e.len      = 3'd6;
                  e.bytes[0] = CH_BSLASH;
                  e.bytes[1] = CH_U;
                  e.bytes[2] = CH_ZERO;
                  e.bytes[3] = CH_ZERO;
                  e.bytes[4] = hex_digit({3'd0, cp[4]});
                  e.bytes[5] = hex_digit(cp[3:0]);
               end else begin
                  e.len = 3'd1; e.bytes[0] = cp[7:0];
               end
            end
         endcase
      end else if (cp < 21'h800) begin
         e.len      = 3'd2;
         e.bytes[0] = {3'b110, cp[10:6]};
         e.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         e.len      = 3'd3;
         e.bytes[0] = {4'b1110, cp[15:12]};
         e.bytes[1] = {2'b10, cp[11:6]};
         e.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         e.len      = 3'd4;
         e.bytes[0] = {5'b11110, cp[20:18]};
         e.bytes[1] = {2'b10, cp[17:12]};
         e.bytes[2] = {2'b10, cp[11:6]};
         e.bytes[3] = {2'b10, cp[5:0]};
      end
      return e;
   endfunction

endpackage

>>> sv/ujes_front.sv
// Front end: accepts UTF-16 words, pairs surrogates and encodes the code point.
// Pushes one entry per word that yields output into ujes_queue. Uses ujes_pkg.
module ujes_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [15:0]       code_unit,
   input  logic              end_of_string,
   output logic              push,
   output ujes_pkg::rec_type push_rec
);
   import ujes_pkg::*;

   logic       high_pending_ff, high_pending_in;
   logic [9:0] high_bits_ff, high_bits_in;
   logic       is_high, is_low;
   logic       main_valid;
   logic [20:0] cp;
   enc_type    enc;

   assign is_high = (code_unit[15:10] == HIGH_SURR_TAG);
   assign is_low  = (code_unit[15:10] == LOW_SURR_TAG);

   always_comb begin
      high_pending_in = high_pending_ff;
      high_bits_in    = high_bits_ff;
      push_rec.prefix = 1'b0;
      main_valid      = 1'b1;
      cp              = {5'd0, code_unit};
      if (high_pending_ff && is_low) begin
         cp = {{1'b0, high_bits_ff} + PLANE_OFFSET, code_unit[9:0]};
      end else begin
         push_rec.prefix = high_pending_ff;
         if (is_high) begin
            if (end_of_string) begin
               cp = CP_REPLACEMENT;
            end else begin
               main_valid   = 1'b0;
               high_bits_in = code_unit[9:0];
            end
         end else if (is_low) begin
            cp = CP_REPLACEMENT;
         end
      end
      if (accept) begin
         high_pending_in = is_high && !end_of_string && !(high_pending_ff && is_low);
      end else begin
         high_bits_in = high_bits_ff;
      end
      enc             = encode_cp(cp);
      push_rec.len    = main_valid ? enc.len : 3'd0;
      push_rec.bytes  = enc.bytes;
      push_rec.at_end = end_of_string;
      push            = accept && (push_rec.prefix || main_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_pending_ff <= 1'b0;
         high_bits_ff    <= '0;
      end else begin
         high_pending_ff <= high_pending_in;
         high_bits_ff    <= high_bits_in;
      end
   end

endmodule

>>> sv/ujes_queue.sv
// Short register queue of encoded entries between the front and back ends.
// Uses ujes_pkg for the entry type and depth.
module ujes_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ujes_pkg::rec_type      push_rec,
   input  logic                   pop,
   output ujes_pkg::q_status_type status,
   output ujes_pkg::rec_type      head_rec
);
   import ujes_pkg::*;

   rec_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.head_valid = (count_ff != '0);
   assign head_rec          = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

>>> sv/ujes_back.sv
// Back end: walks the head queue entry into the output register, one byte per cycle
// unless rsp_tready stalls. Uses ujes_pkg for the entry type and U+FFFD byte table.
module ujes_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ujes_pkg::q_status_type status,
   input  ujes_pkg::rec_type      head_rec,
   output logic                   pop,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tuser
);
   import ujes_pkg::*;

   logic       main_phase_ff, main_phase_in;
   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       done_ff, done_in;
   logic       in_prefix, seg_last, rec_last, step;

   assign in_prefix = head_rec.prefix && !main_phase_ff;
   assign seg_last  = in_prefix ? (idx_ff == 3'd2) : (idx_ff == head_rec.len - 3'd1);
   assign rec_last  = seg_last && (!in_prefix || (head_rec.len == 3'd0));
   assign step      = status.head_valid && (!valid_ff || rsp_tready);
   assign pop       = step && rec_last;

   always_comb begin
      main_phase_in = main_phase_ff;
      idx_in        = idx_ff;
      valid_in      = valid_ff && !rsp_tready;
      byte_in       = byte_ff;
      last_in       = last_ff;
      done_in       = done_ff;
      if (step) begin
         valid_in = 1'b1;
         byte_in  = in_prefix ? FFFD_UTF8[idx_ff[1:0]] : head_rec.bytes[idx_ff];
         last_in  = rec_last;
         done_in  = rec_last && head_rec.at_end;
         if (rec_last) begin
            main_phase_in = 1'b0;
            idx_in        = 3'd0;
         end else if (seg_last) begin
            // Replacement character done; continue with the code point proper.
            main_phase_in = 1'b1;
            idx_in        = 3'd0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_phase_ff <= 1'b0;
         idx_ff        <= '0;
         valid_ff      <= 1'b0;
      end else begin
         main_phase_ff <= main_phase_in;
         idx_ff        <= idx_in;
         valid_ff      <= valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = done_ff;

endmodule

>>> sv/utf16_to_utf8_json_escaper_top.sv
// Converts UTF-16 words to UTF-8 bytes with JSON string escaping. A word is taken in
// every cycle while the four-entry queue between front and back end has room; the back
// end sends one byte per cycle while rsp_tready does not stall it, so a word's output
// bytes (1 to 9) go out in turn, and the sustained rate is one word per cycle for plain
// ASCII text. A high surrogate that is not at the end of a string produces nothing until
// the next word. Depends on ujes_pkg, ujes_front, ujes_queue and ujes_back.
module utf16_to_utf8_json_escaper_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] code_unit
   input  logic        req_tlast,   // end_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // last_of_run
   output logic        rsp_tuser    // [0] string_done
);
   import ujes_pkg::*;

   logic         push, pop;
   rec_type      push_rec, head_rec;
   q_status_type status;

   assign req_tready = !status.full;

   ujes_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_tvalid && req_tready),
      .code_unit     (req_tdata),
      .end_of_string (req_tlast),
      .push          (push),
      .push_rec      (push_rec)
   );

   ujes_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .status   (status),
      .head_rec (head_rec)
   );

   ujes_back u_back (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .head_rec   (head_rec),
      .pop        (pop),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> sv/ujes_checker.sv
// Port-level checks for utf16_to_utf8_json_escaper_top, attached by bind.
// Depends only on the top level's ports.
module ujes_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // A stalled word keeps its payload until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   // The end of a string is always the end of a word's byte run.
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("string_done without last_of_run");

   // Nothing is offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // A byte that starts being offered must go back to a word taken in earlier; none is invented.
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !$past(rsp_tvalid) && rsp_tvalid |-> $past(req_tvalid && req_tready, 2)
         || $past(rsp_tvalid, 2) || $past(req_tvalid, 3) || $past(req_tvalid, 4)
         || $past(req_tvalid, 5) || $past(req_tvalid, 6))
      else $error("rsp word without any input");

endmodule

bind utf16_to_utf8_json_escaper_top ujes_checker u_ujes_checker (.*);

>>> bench/testbench.sv
// Self-checking bench for the UTF-16 to UTF-8 JSON escaper: directed corner words, then
// random strings under random stalls on both sides. Needs utf16_to_utf8_json_escaper_top
// and ujes_pkg; the expected bytes are computed here from first principles.
`timescale 1ns / 1ps

typedef struct packed {
   logic [7:0] value;
   logic       run_end;
   logic       text_end;
} text_byte_type;

class utf8_scoreboard;
   localparam logic [15:0] HIGH_FIRST  = 16'hD800;
   localparam logic [15:0] HIGH_LAST   = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST   = 16'hDC00;
   localparam logic [15:0] LOW_LAST    = 16'hDFFF;
   localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
   localparam logic [7:0]  BSLASH      = 8'h5C;
   localparam logic [7:0]  QUOTE       = 8'h22;
   localparam logic [7:0]  LINE_FEED   = 8'h0A;
   localparam logic [7:0]  CAR_RETURN  = 8'h0D;
   localparam logic [7:0]  HTAB        = 8'h09;

   text_byte_type expected_bytes[$];
   logic [7:0]    word_bytes[$];
   bit            high_held;
   logic [9:0]    held_bits;
   int            errors;

   function new();
      high_held = 1'b0;
      held_bits = '0;
      errors    = 0;
   endfunction

   function logic [7:0] hex_char(input logic [3:0] v);
      return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h41 + 8'(v) - 8'd10;
   endfunction

   function void append_byte(input logic [7:0] v);
      word_bytes = {word_bytes, v};
   endfunction

   function void add_code_point(input logic [20:0] cp);
      if (cp < 21'h80) begin
         if (cp[7:0] == QUOTE || cp[7:0] == BSLASH) begin
            append_byte(BSLASH);
            append_byte(cp[7:0]);
         end else if (cp[7:0] == LINE_FEED) begin
            append_byte(BSLASH);
            append_byte(8'h6E);
         end else if (cp[7:0] == CAR_RETURN) begin
            append_byte(BSLASH);
            append_byte(8'h72);
         end else if (cp[7:0] == HTAB) begin
            append_byte(BSLASH);
            append_byte(8'h74);
         end else if (cp < 21'h20) begin
            append_byte(BSLASH);
            append_byte(8'h75);
            append_byte(8'h30);
            append_byte(8'h30);
            append_byte(hex_char(cp[7:4]));
            append_byte(hex_char(cp[3:0]));
         end else begin
            append_byte(cp[7:0]);
         end
      end else if (cp < 21'h800) begin
         append_byte(8'hC0 | 8'(cp >> 6));
         append_byte(8'h80 | 8'(cp & 21'h3F));
      end else if (cp < 21'h10000) begin
         append_byte(8'hE0 | 8'(cp >> 12));
         append_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
         append_byte(8'h80 | 8'(cp & 21'h3F));
      end else begin
         append_byte(8'hF0 | 8'((cp >> 18) & 21'h07));
         append_byte(8'h80 | 8'((cp >> 12) & 21'h3F));
         append_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
         append_byte(8'h80 | 8'(cp & 21'h3F));
      end
   endfunction

   // A word seen with no high surrogate waiting.
   function void add_fresh(input logic [15:0] unit, input bit at_end);
      if (unit >= HIGH_FIRST && unit <= HIGH_LAST) begin
         if (at_end) begin
            add_code_point(REPLACEMENT);
         end else begin
            high_held = 1'b1;
            held_bits = unit[9:0];
         end
      end else if (unit >= LOW_FIRST && unit <= LOW_LAST) begin
         add_code_point(REPLACEMENT);
      end else begin
         add_code_point(21'(unit));
      end
   endfunction

   function void note_word(input logic [15:0] unit, input bit at_end);
      text_byte_type b;
      logic [9:0]    upper;
      word_bytes.delete();
      if (high_held) begin
         upper     = held_bits;
         high_held = 1'b0;
         held_bits = '0;
         if (unit >= LOW_FIRST && unit <= LOW_LAST) begin
            add_code_point(21'h10000 + 21'({upper, unit[9:0]}));
         end else begin
            add_code_point(REPLACEMENT);
            add_fresh(unit, at_end);
         end
      end else begin
         add_fresh(unit, at_end);
      end
      foreach (word_bytes[k]) begin
         b.value        = word_bytes[k];
         b.run_end      = (k == word_bytes.size() - 1);
         b.text_end     = b.run_end && at_end;
         expected_bytes = {expected_bytes, b};
      end
   endfunction

   function void check_byte(input logic [7:0] value, input logic run_end,
                            input logic text_end);
      text_byte_type want;
      if (expected_bytes.size() == 0) begin
         errors++;
         $display("%0t: unexpected byte, expected none, actual %h last %b done %b",
                  $time, value, run_end, text_end);
         return;
      end
      want = expected_bytes.pop_front();
      if (value !== want.value || run_end !== want.run_end
          || text_end !== want.text_end) begin
         errors++;
         $display("%0t: byte mismatch, expected %h last %b done %b, actual %h last %b done %b",
                  $time, want.value, want.run_end, want.text_end, value, run_end, text_end);
      end
   endfunction
endclass

module testbench;
   localparam int RANDOM_WORDS = 80;
   localparam int HOLD_CYCLES  = 80;
   localparam int IDLE_LIMIT   = 1000;
   localparam int SETTLE       = 20;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   utf8_scoreboard board = new();
   int  words_sent   = 0;
   bit  hold_request = 1'b0;
   bit  holding      = 1'b0;

   // Bit 16 is the end-of-string flag, bits 15:0 the code unit.
   logic [16:0] directed_words [0:23] = '{
      17'h00022, 17'h0005C, 17'h0000A, 17'h0000D, 17'h00009, 17'h00000,
      17'h0001F, 17'h00020, 17'h0007F, 17'h00080, 17'h007FF, 17'h00800,
      17'h1FFFF, 17'h0D800, 17'h0DC00, 17'h0DBFF, 17'h1DFFF, 17'h0DFFF,
      17'h0D834, 17'h00041, 17'h0D800, 17'h0DBFF, 17'h1001B, 17'h1DBFF
   };

   utf16_to_utf8_json_escaper_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   task automatic send_word(input logic [15:0] unit, input logic at_end, input bit busy);
      int gap;
      gap = busy ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= unit;
      req_tlast  <= at_end;
      do @(posedge clock); while (!req_tready);
      board.note_word(unit, at_end);
      words_sent++;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.expected_bytes.size() != 0) @(negedge clock);
   endtask

   // A string of one to eight characters, most of them well formed, ending with the flag.
   task automatic send_random_string(input bit busy);
      int          len;
      int          r;
      bit          last;
      logic [15:0] unit;
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
         last = (i == len - 1);
         r    = $urandom_range(0, 99);
         if (r < 70 || r >= 88) begin
            if (r < 25) begin
               unit = 16'($urandom_range(16'h20, 16'h7F));
            end else if (r < 35) begin
               case ($urandom_range(0, 4))
                  0:       unit = 16'h0022;
                  1:       unit = 16'h005C;
                  2:       unit = 16'h000A;
                  3:       unit = 16'h000D;
                  default: unit = 16'h0009;
               endcase
            end else if (r < 43) begin
               unit = 16'($urandom_range(0, 16'h1F));
            end else if (r < 55) begin
               unit = 16'($urandom_range(16'h80, 16'h7FF));
            end else if (r < 70) begin
               unit = $urandom_range(0, 1) ? 16'($urandom_range(16'h800, 16'hD7FF))
                                           : 16'($urandom_range(16'hE000, 16'hFFFF));
            end else if (r < 94) begin
               unit = 16'($urandom_range(16'hD800, 16'hDFFF));
            end else begin
               unit = 16'($urandom());
            end
            send_word(unit, last, busy);
         end else begin
            send_word(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0, busy);
            send_word(16'($urandom_range(16'hDC00, 16'hDFFF)), last, busy);
         end
      end
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int stall;
      int run;
      wait (!reset);
      forever begin
         if (hold_request) begin
            holding = 1'b1;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
            holding      = 1'b0;
            hold_request = 1'b0;
         end else begin
            stall = pick_gap();
            run   = $urandom_range(1, 16);
            repeat (stall) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
            repeat (run) begin
               @(negedge clock);
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   initial begin
      logic [7:0] value;
      logic       run_end;
      logic       text_end;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            value    = rsp_tdata;
            run_end  = rsp_tlast;
            text_end = rsp_tuser;
            // Check after the words accepted at this same edge have been noted.
            #1;
            board.check_byte(value, run_end, text_end);
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      wait (!reset);
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      bit pressed;
      pressed = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_words[i]) begin
         send_word(directed_words[i][15:0], directed_words[i][16], 1'b0);
      end
      wait_for_drain();

      while (words_sent < $size(directed_words) + RANDOM_WORDS) begin
         if (!pressed && words_sent > $size(directed_words) + RANDOM_WORDS / 2) begin
            // Offer back-to-back words while the result side is held off.
            @(negedge clock);
            req_tvalid   <= 1'b0;
            hold_request = 1'b1;
            wait (holding);
            repeat (4) send_random_string(1'b1);
            pressed = 1'b1;
            wait_for_drain();
         end else begin
            send_random_string(1'b0);
         end
      end
      wait_for_drain();
      repeat (SETTLE) @(posedge clock);

      if (board.errors == 0 && board.expected_bytes.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
